### src/dst_pkg.sv
package dst_pkg;

   localparam int DAYS        = 7;
   localparam int MAX_ENTRIES = 32;

   // port field widths
   localparam int ACT_W       = 3;
   localparam int DAY_W       = 3;
   localparam int SLOT_W      = 5;
   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int OUT_CNT_W   = 6;
   localparam int ENTRY_W     = HOUR_W + MINUTE_W + 1;

   // derived widths
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int DAY_IDX_W   = (DAYS > 1) ? $clog2(DAYS) : 1;
   localparam int MEM_DEPTH   = DAYS * MAX_ENTRIES;
   localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int CMP_W       = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   // action codes
   localparam logic [ACT_W-1:0] ACT_INSERT    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR_DAY = 3'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR_ALL = 3'd3;
   localparam logic [ACT_W-1:0] ACT_UPDATE    = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

endpackage

### src/day_schedule_table_core.sv
// Weekly switching schedule: one list of up to MAX_ENTRIES entries per day, held in a single
// entry memory (one write and one registered read port per cycle) with a day count register
// per day. One request is taken at a time. Clear day, clear all, an update, an insert into a
// full day and any request rejected at decode go from the decode state straight to the done
// state and the result register. Insert reads the day's list once for a duplicate check and
// stops early when a duplicate turns up; delete moves the entries above the slot down one
// per cycle. Both walks are bound by the single memory read port. A new request is taken
// as soon as the previous result is in the output register, and the entry memory needs no
// clearing after reset.
module day_schedule_table_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dst_pkg::ACT_W-1:0]      req_action,
   input  logic [dst_pkg::DAY_W-1:0]      req_day,
   input  logic [dst_pkg::SLOT_W-1:0]     req_slot,
   input  logic [dst_pkg::HOUR_W-1:0]     req_entry_hour,
   input  logic [dst_pkg::MINUTE_W-1:0]   req_entry_minute,
   input  logic                           req_entry_on,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_ok,
   output logic [dst_pkg::OUT_CNT_W-1:0]  rsp_day_count
);

   localparam int CNT_W   = dst_pkg::CNT_W;
   localparam int IDX_W   = dst_pkg::IDX_W;
   localparam int ADDR_W  = dst_pkg::ADDR_W;
   localparam int ENTRY_W = dst_pkg::ENTRY_W;
   localparam int CMP_W   = dst_pkg::CMP_W;

   dst_pkg::state_type state_ff, state_in;

   logic [dst_pkg::ACT_W-1:0]  act_ff, act_in;
   logic [dst_pkg::DAY_W-1:0]  day_ff, day_in;
   logic [dst_pkg::SLOT_W-1:0] slot_ff, slot_in;
   logic [ENTRY_W-1:0]         entry_ff, entry_in;
   logic [ADDR_W-1:0]          base_ff, base_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic                       pend_ff, pend_in;
   logic [CNT_W-1:0]           pend_idx_ff, pend_idx_in;
   logic                       res_ok_ff, res_ok_in;
   logic [CNT_W-1:0]           res_cnt_ff, res_cnt_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_ok_ff, rsp_ok_in;
   logic [dst_pkg::OUT_CNT_W-1:0]    rsp_day_count_ff, rsp_day_count_in;

   logic [CNT_W-1:0] counts_ff [dst_pkg::DAYS];

   // entry memory
   logic [ENTRY_W-1:0] entry_mem [dst_pkg::MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               rd_issue;
   logic [ADDR_W-1:0]  mem_raddr;

   // day count updates
   logic             cnt_we;
   logic [CNT_W-1:0] cnt_wdata;
   logic             cnt_clear_all;

   logic                           accept;
   logic                           req_day_ok;
   logic                           day_ok;
   logic [dst_pkg::DAY_IDX_W-1:0]  day_idx;
   logic [CNT_W-1:0]               cur_count;
   logic                           slot_hit;
   logic                           more_reads;
   logic [CNT_W-1:0]               shift_dst;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != dst_pkg::ST_IDLE);
   assign req_day_ok = (req_day < dst_pkg::DAY_W'(dst_pkg::DAYS));
   assign day_ok     = (day_ff < dst_pkg::DAY_W'(dst_pkg::DAYS));
   assign day_idx    = day_ff[dst_pkg::DAY_IDX_W-1:0];
   assign cur_count  = req_day_ok ? counts_ff[req_day[dst_pkg::DAY_IDX_W-1:0]] : '0;
   assign slot_hit   = (CMP_W'(slot_ff) < CMP_W'(count_ff));
   assign more_reads = (idx_ff < count_ff);
   assign shift_dst  = pend_idx_ff - CNT_W'(1);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_day_count = rsp_day_count_ff;

   always_comb begin
      state_in         = state_ff;
      act_in           = act_ff;
      day_in           = day_ff;
      slot_in          = slot_ff;
      entry_in         = entry_ff;
      base_in          = base_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      pend_in          = 1'b0;
      pend_idx_in      = idx_ff;
      res_ok_in        = res_ok_ff;
      res_cnt_in       = res_cnt_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_ok_in        = rsp_ok_ff;
      rsp_day_count_in = rsp_day_count_ff;
      mem_we           = 1'b0;
      mem_waddr        = base_ff + ADDR_W'(slot_ff[IDX_W-1:0]);
      mem_wdata        = entry_ff;
      rd_issue         = 1'b0;
      mem_raddr        = base_ff + ADDR_W'(idx_ff[IDX_W-1:0]);
      cnt_we           = 1'b0;
      cnt_wdata        = count_ff;
      cnt_clear_all    = 1'b0;

      unique case (state_ff)
         dst_pkg::ST_IDLE: begin
            if (accept) begin
               act_in   = req_action;
               day_in   = req_day;
               slot_in  = req_slot;
               entry_in = {req_entry_hour, req_entry_minute, req_entry_on};
               base_in  = ADDR_W'(req_day[dst_pkg::DAY_IDX_W-1:0])
                          * ADDR_W'(dst_pkg::MAX_ENTRIES);
               count_in = cur_count;
               state_in = dst_pkg::ST_DECODE;
            end
         end

         dst_pkg::ST_DECODE: begin
            res_ok_in  = 1'b0;
            res_cnt_in = count_ff;
            state_in   = dst_pkg::ST_DONE;
            priority if (act_ff == dst_pkg::ACT_CLEAR_ALL) begin
               cnt_clear_all = 1'b1;
               res_ok_in     = 1'b1;
               res_cnt_in    = '0;
            end else if (!day_ok) begin
               res_cnt_in = '0;
            end else if (act_ff == dst_pkg::ACT_INSERT) begin
               if (count_ff < CNT_W'(dst_pkg::MAX_ENTRIES)) begin
                  idx_in   = '0;
                  state_in = dst_pkg::ST_SCAN;
               end
            end else if (act_ff == dst_pkg::ACT_DELETE) begin
               if (slot_hit) begin
                  idx_in   = CNT_W'(slot_ff) + CNT_W'(1);
                  state_in = dst_pkg::ST_SHIFT;
               end
            end else if (act_ff == dst_pkg::ACT_CLEAR_DAY) begin
               cnt_we     = 1'b1;
               cnt_wdata  = '0;
               res_ok_in  = 1'b1;
               res_cnt_in = '0;
            end else if (act_ff == dst_pkg::ACT_UPDATE) begin
               if (slot_hit) begin
                  mem_we    = 1'b1;
                  res_ok_in = 1'b1;
               end
            end else begin
               res_ok_in = 1'b0;
            end
         end

         dst_pkg::ST_SCAN: begin
            // stream reads one entry per cycle, compare on the next cycle
            rd_issue    = more_reads;
            pend_in     = more_reads;
            pend_idx_in = idx_ff;
            if (more_reads) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff && (rd_data_ff == entry_ff)) begin
               pend_in    = 1'b0;
               res_ok_in  = 1'b0;
               res_cnt_in = count_ff;
               state_in   = dst_pkg::ST_DONE;
            end else if (!more_reads && !pend_ff) begin
               mem_we     = 1'b1;
               mem_waddr  = base_ff + ADDR_W'(count_ff[IDX_W-1:0]);
               cnt_we     = 1'b1;
               cnt_wdata  = count_ff + CNT_W'(1);
               res_ok_in  = 1'b1;
               res_cnt_in = count_ff + CNT_W'(1);
               state_in   = dst_pkg::ST_DONE;
            end
         end

         dst_pkg::ST_SHIFT: begin
            // read runs one entry ahead of the write, so no overlap on an entry
            rd_issue    = more_reads;
            pend_in     = more_reads;
            pend_idx_in = idx_ff;
            if (more_reads) begin
               idx_in = idx_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = base_ff + ADDR_W'(shift_dst[IDX_W-1:0]);
               mem_wdata = rd_data_ff;
            end
            if (!more_reads && !pend_ff) begin
               cnt_we     = 1'b1;
               cnt_wdata  = count_ff - CNT_W'(1);
               res_ok_in  = 1'b1;
               res_cnt_in = count_ff - CNT_W'(1);
               state_in   = dst_pkg::ST_DONE;
            end
         end

         dst_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in     = 1'b1;
               rsp_ok_in        = res_ok_ff;
               rsp_day_count_in = dst_pkg::OUT_CNT_W'(res_cnt_ff);
               state_in         = dst_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dst_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dst_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff           <= act_in;
      day_ff           <= day_in;
      slot_ff          <= slot_in;
      entry_ff         <= entry_in;
      base_ff          <= base_in;
      count_ff         <= count_in;
      idx_ff           <= idx_in;
      pend_idx_ff      <= pend_idx_in;
      res_ok_ff        <= res_ok_in;
      res_cnt_ff       <= res_cnt_in;
      rsp_ok_ff        <= rsp_ok_in;
      rsp_day_count_ff <= rsp_day_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < dst_pkg::DAYS; d++) begin
            counts_ff[d] <= '0;
         end
      end else if (cnt_clear_all) begin
         for (int d = 0; d < dst_pkg::DAYS; d++) begin
            counts_ff[d] <= '0;
         end
      end else if (cnt_we) begin
         counts_ff[day_idx] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_issue) begin
         rd_data_ff <= entry_mem[mem_raddr];
      end
   end

endmodule

### bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [dst_pkg::ACT_W-1:0]    action;
      logic [dst_pkg::DAY_W-1:0]    day;
      logic [dst_pkg::SLOT_W-1:0]   slot;
      logic [dst_pkg::HOUR_W-1:0]   entry_hour;
      logic [dst_pkg::MINUTE_W-1:0] entry_minute;
      logic                         entry_on;
      logic                         hold;
   } sched_req_type;

   typedef struct packed {
      logic                          ok;
      logic [dst_pkg::OUT_CNT_W-1:0] day_count;
   } sched_rsp_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [dst_pkg::ACT_W-1:0]      req_action = '0;
   logic [dst_pkg::DAY_W-1:0]      req_day = '0;
   logic [dst_pkg::SLOT_W-1:0]     req_slot = '0;
   logic [dst_pkg::HOUR_W-1:0]     req_entry_hour = '0;
   logic [dst_pkg::MINUTE_W-1:0]   req_entry_minute = '0;
   logic                           req_entry_on = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_ok;
   logic [dst_pkg::OUT_CNT_W-1:0]  rsp_day_count;

   // predicted table contents
   logic [dst_pkg::ENTRY_W-1:0] day_words [dst_pkg::DAYS][dst_pkg::MAX_ENTRIES];
   int                          day_fill  [dst_pkg::DAYS];

   sched_req_type req_backlog [$];
   sched_rsp_type rsp_due [$];
   int            acc_n = 0;
   int            rsp_n = 0;
   int            mismatch_n = 0;
   int            backlog_cyc = 0;
   bit            backlog_done = 1'b0;

   day_schedule_table_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_day          (req_day),
      .req_slot         (req_slot),
      .req_entry_hour   (req_entry_hour),
      .req_entry_minute (req_entry_minute),
      .req_entry_on     (req_entry_on),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_ok           (rsp_ok),
      .rsp_day_count    (rsp_day_count)
   );

   always #5 clock = ~clock;

   function automatic sched_rsp_type schedule_apply(sched_req_type r);
      sched_rsp_type               res;
      logic [dst_pkg::ENTRY_W-1:0] word;
      int                          n;
      bit                          seen;
      word = {r.entry_hour, r.entry_minute, r.entry_on};
      res.ok = 1'b0;
      res.day_count = '0;
      if (r.action == dst_pkg::ACT_CLEAR_ALL) begin
         for (int d = 0; d < dst_pkg::DAYS; d++) day_fill[d] = 0;
         res.ok = 1'b1;
         return res;
      end
      if (r.day >= dst_pkg::DAYS) return res;
      n = day_fill[r.day];
      case (r.action)
         dst_pkg::ACT_INSERT: begin
            seen = 1'b0;
            for (int i = 0; i < n; i++)
               if (day_words[r.day][i] == word) seen = 1'b1;
            if (n < dst_pkg::MAX_ENTRIES && !seen) begin
               day_words[r.day][n] = word;
               n++;
               res.ok = 1'b1;
            end
         end
         dst_pkg::ACT_DELETE: begin
            if (r.slot < n) begin
               for (int i = r.slot; i < n - 1; i++)
                  day_words[r.day][i] = day_words[r.day][i + 1];
               n--;
               res.ok = 1'b1;
            end
         end
         dst_pkg::ACT_CLEAR_DAY: begin
            n = 0;
            res.ok = 1'b1;
         end
         dst_pkg::ACT_UPDATE: begin
            if (r.slot < n) begin
               day_words[r.day][r.slot] = word;
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      day_fill[r.day] = n;
      res.day_count = n[dst_pkg::OUT_CNT_W-1:0];
      return res;
   endfunction

   task automatic add_req(input int act, input int day, input int slot, input int hour,
                          input int minute, input int on);
      sched_req_type r;
      r.action       = act[dst_pkg::ACT_W-1:0];
      r.day          = day[dst_pkg::DAY_W-1:0];
      r.slot         = slot[dst_pkg::SLOT_W-1:0];
      r.entry_hour   = hour[dst_pkg::HOUR_W-1:0];
      r.entry_minute = minute[dst_pkg::MINUTE_W-1:0];
      r.entry_on     = on[0];
      r.hold         = 1'b0;
      req_backlog.insert(req_backlog.size(), r);
   endtask

   // request driver
   always @(posedge clock) begin : drive_proc
      int            acc_now;
      sched_req_type cur;
      bit            quiet;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         acc_now = acc_n + ((req_valid && !req_stall) ? 1 : 0);
         acc_n <= acc_now;
         quiet = (acc_now >= 700 && acc_now < 900);
         if (!req_valid || !req_stall) begin
            if (req_backlog.size() != 0 && !(req_backlog[0].hold && rsp_n != acc_now) &&
                (quiet || $urandom_range(0, 99) >= 35)) begin
               cur = req_backlog.pop_front();
               req_action       <= cur.action;
               req_day          <= cur.day;
               req_slot         <= cur.slot;
               req_entry_hour   <= cur.entry_hour;
               req_entry_minute <= cur.entry_minute;
               req_entry_on     <= cur.entry_on;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall: one long hold-off, a quiet stretch, random otherwise
   always @(posedge clock) begin : stall_proc
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (!backlog_done && rsp_n >= 300) begin
         rsp_stall <= 1'b1;
         backlog_cyc <= backlog_cyc + 1;
         if (backlog_cyc == 400) backlog_done <= 1'b1;
      end else if (rsp_n >= 700 && rsp_n < 900) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 35);
      end
   end

   // checks results against the oldest prediction, predicts on each accepted request
   always @(posedge clock) begin : watch_proc
      sched_rsp_type want;
      sched_req_type seen_req;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_n <= rsp_n + 1;
            if (rsp_due.size() == 0) begin
               $error("result with no request outstanding: ok %0d day_count %0d",
                      rsp_ok, rsp_day_count);
               mismatch_n++;
            end else begin
               want = rsp_due.pop_front();
               if (rsp_ok !== want.ok) begin
                  $error("ok mismatch: expected %0d actual %0d", want.ok, rsp_ok);
                  mismatch_n++;
               end
               if (rsp_day_count !== want.day_count) begin
                  $error("day_count mismatch: expected %0d actual %0d",
                         want.day_count, rsp_day_count);
                  mismatch_n++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            seen_req.action       = req_action;
            seen_req.day          = req_day;
            seen_req.slot         = req_slot;
            seen_req.entry_hour   = req_entry_hour;
            seen_req.entry_minute = req_entry_minute;
            seen_req.entry_on     = req_entry_on;
            seen_req.hold         = 1'b0;
            rsp_due.insert(rsp_due.size(), schedule_apply(seen_req));
         end
      end
   end

   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stim_proc
      int day, pick, n, k, hr, mn, on, r, first_rand, target;
      int issued [$];

      for (int d = 0; d < dst_pkg::DAYS; d++) day_fill[d] = 0;

      // directed
      add_req(dst_pkg::ACT_INSERT, 0, 0, 0, 0, 0);
      add_req(dst_pkg::ACT_INSERT, 0, 31, 23, 59, 1);
      add_req(dst_pkg::ACT_INSERT, 0, 0, 0, 0, 0);          // duplicate
      add_req(dst_pkg::ACT_INSERT, 6, 31, 31, 63, 1);       // all field bits high
      add_req(dst_pkg::ACT_UPDATE, 0, 1, 12, 30, 0);
      add_req(dst_pkg::ACT_UPDATE, 0, 2, 5, 5, 1);          // slot not occupied
      add_req(dst_pkg::ACT_UPDATE, 0, 31, 5, 5, 1);
      add_req(dst_pkg::ACT_DELETE, 0, 5, 0, 0, 0);
      add_req(dst_pkg::ACT_DELETE, 0, 0, 0, 0, 0);
      add_req(dst_pkg::ACT_INSERT, 7, 0, 1, 1, 1);          // day out of range
      add_req(dst_pkg::ACT_DELETE, 7, 0, 0, 0, 0);
      add_req(dst_pkg::ACT_CLEAR_DAY, 7, 0, 0, 0, 0);
      add_req(dst_pkg::ACT_UPDATE, 7, 0, 2, 2, 0);
      add_req(dst_pkg::ACT_INSERT, 3, 0, 8, 16, 0);
      add_req(dst_pkg::ACT_INSERT, 3, 0, 15, 47, 1);
      add_req(dst_pkg::ACT_CLEAR_DAY, 3, 0, 0, 0, 0);
      add_req(dst_pkg::ACT_INSERT, 6, 0, 1, 2, 0);
      add_req(5, 6, 0, 0, 0, 0);                            // unknown actions
      add_req(6, 0, 3, 0, 0, 0);
      add_req(7, 7, 0, 0, 0, 0);
      add_req(dst_pkg::ACT_CLEAR_ALL, 7, 31, 31, 63, 1);
      add_req(7, 6, 0, 0, 0, 0);
      add_req(dst_pkg::ACT_DELETE, 0, 0, 0, 0, 0);

      // random bursts
      first_rand = req_backlog.size();
      target = first_rand + 1450;
      while (req_backlog.size() < target) begin
         day = $urandom_range(0, dst_pkg::DAYS - 1);
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            // fill one day, sometimes repeating an earlier entry
            issued.delete();
            n = $urandom_range(34, 44);
            repeat (n) begin
               if (issued.size() != 0 && $urandom_range(0, 99) < 12) begin
                  k = issued[$urandom_range(0, issued.size() - 1)];
                  add_req(dst_pkg::ACT_INSERT, day, $urandom_range(0, 31), k >> 7,
                          (k >> 1) & 63, k & 1);
               end else begin
                  hr = $urandom_range(0, 23);
                  mn = $urandom_range(0, 59);
                  on = $urandom_range(0, 1);
                  issued.insert(issued.size(), (hr << 7) | (mn << 1) | on);
                  add_req(dst_pkg::ACT_INSERT, day, $urandom_range(0, 31), hr, mn, on);
               end
            end
         end else if (pick < 88) begin
            n = $urandom_range(8, 24);
            repeat (n) begin
               r = $urandom_range(0, 99);
               k = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 31);
               if (r < 35)
                  add_req(dst_pkg::ACT_INSERT, day, k, $urandom_range(0, 3),
                          $urandom_range(0, 3), $urandom_range(0, 1));
               else if (r < 60)
                  add_req(dst_pkg::ACT_DELETE, day, k, $urandom_range(0, 31),
                          $urandom_range(0, 63), $urandom_range(0, 1));
               else if (r < 90)
                  add_req(dst_pkg::ACT_UPDATE, day, k, $urandom_range(0, 23),
                          $urandom_range(0, 59), $urandom_range(0, 1));
               else if (r < 95)
                  add_req(dst_pkg::ACT_CLEAR_DAY, day, k, $urandom_range(0, 31),
                          $urandom_range(0, 63), $urandom_range(0, 1));
               else
                  add_req(dst_pkg::ACT_INSERT, day, k, $urandom_range(0, 23),
                          $urandom_range(0, 59), $urandom_range(0, 1));
            end
         end else begin
            n = $urandom_range(4, 12);
            repeat (n)
               add_req($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 31),
                       $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 1));
         end
      end
      // drain points for the sender
      req_backlog[first_rand].hold = 1'b1;
      req_backlog[first_rand + 1000].hold = 1'b1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (rsp_due.size() != 0) begin
         $error("%0d predicted results never arrived", rsp_due.size());
         mismatch_n++;
      end
      if (mismatch_n == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
